// File: src/constant_velocity_kalman_tracker_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the constant-velocity Kalman tracker.
// Each macro checks a property on the rising clock edge and is off during reset.
// ---------------------------------------------------------------------------
`ifndef CONSTANT_VELOCITY_KALMAN_TRACKER_ASSERT_SVH
`define CONSTANT_VELOCITY_KALMAN_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVKT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CVKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

// File: src/cvkt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cvkt_pkg
// Shared widths, register codes and the request type of the arithmetic unit.
// ---------------------------------------------------------------------------
package cvkt_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

  localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET     = 32'd4294967;
  localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RESET = 32'd214748;

  localparam int unsigned MUL_W  = 64;
  localparam int unsigned PROD_W = 128;
  localparam int unsigned NUM_W  = 113;
  localparam int unsigned DEN_W  = 99;
  localparam int unsigned QUO_W  = 34;
  localparam int unsigned GAIN_W = 33;

  typedef struct packed {
    logic start;
    logic is_div;
  } cvkt_arith_req_t;

endpackage
`default_nettype wire

// File: src/cvkt_arith.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cvkt_arith
// Shared multi-cycle unit: signed multiply in 16-bit digits, or a clipped
// unsigned restoring division one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cvkt_arith import cvkt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cvkt_arith_req_t           req_i,
  input  logic signed [MUL_W-1:0]   mul_a_i,
  input  logic signed [MUL_W-1:0]   mul_b_i,
  input  logic        [NUM_W-1:0]   div_num_i,
  input  logic        [DEN_W-1:0]   div_den_i,
  output logic                      done_o,
  output logic signed [PROD_W-1:0]  prod_o,
  output logic        [GAIN_W-1:0]  quot_o
);

  localparam logic [5:0] MulSteps = 6'd4;
  localparam logic [5:0] DivSteps = 6'd34;

  logic             busy_q;
  logic [5:0]       cnt_q;
  logic [MUL_W-1:0] ma_q, mb_q;
  logic             neg_q;
  logic [PROD_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] qsh_q, q_q;
  logic             ovf_q;

  logic             ovf_start;
  logic [79:0]      part;
  logic [DEN_W:0]   trial;
  logic             trial_ge;
  logic [MUL_W-1:0] mag_a, mag_b;

  assign mag_a     = mul_a_i[MUL_W-1] ? MUL_W'(-mul_a_i) : MUL_W'(mul_a_i);
  assign mag_b     = mul_b_i[MUL_W-1] ? MUL_W'(-mul_b_i) : MUL_W'(mul_b_i);
  assign ovf_start = {20'd0, div_num_i[NUM_W-1:QUO_W]} >= div_den_i;
  assign part      = ma_q * mb_q[MUL_W-1:MUL_W-16];
  assign trial     = {rem_q, qsh_q[QUO_W-1]};
  assign trial_ge  = trial >= {1'b0, den_q};

  assign done_o = busy_q && (cnt_q == 6'd0);
  assign prod_o = neg_q ? -$signed(acc_q) : $signed(acc_q);
  assign quot_o = (ovf_q || (q_q > 34'h1_0000_0000)) ? 33'h1_0000_0000 : q_q[GAIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.is_div ? (ovf_start ? 6'd0 : DivSteps) : MulSteps;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ma_q  <= mag_a;
      mb_q  <= mag_b;
      neg_q <= (!req_i.is_div) && (mul_a_i[MUL_W-1] != mul_b_i[MUL_W-1]);
      acc_q <= '0;
      rem_q <= {20'd0, div_num_i[NUM_W-1:QUO_W]};
      qsh_q <= div_num_i[QUO_W-1:0];
      q_q   <= '0;
      den_q <= div_den_i;
      ovf_q <= ovf_start;
    end else if (busy_q && (cnt_q != 6'd0)) begin
      acc_q <= (acc_q << 16) + {48'd0, part};
      mb_q  <= mb_q << 16;
      qsh_q <= qsh_q << 1;
      if (trial_ge) begin
        rem_q <= DEN_W'(trial - {1'b0, den_q});
        q_q   <= {q_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DEN_W-1:0];
        q_q   <= {q_q[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: src/cvkt_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cvkt_core
// Sequencer and state of the tracker: runs the x and y axes in turn through
// the shared arithmetic unit and holds positions, velocities and covariance.
// ---------------------------------------------------------------------------
module cvkt_core import cvkt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic signed [31:0]       cur_x_i,
  input  logic signed [31:0]       cur_y_i,
  input  logic signed [31:0]       prev_x_i,
  input  logic signed [31:0]       prev_y_i,
  input  logic        [CFG_W-1:0]  r_i,
  input  logic        [CFG_W-1:0]  qn_i,
  input  logic                     res_free_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  output logic signed [31:0]       pos_x_o,
  output logic signed [31:0]       pos_y_o,
  output cvkt_arith_req_t          arith_req_o,
  output logic signed [MUL_W-1:0]  mul_a_o,
  output logic signed [MUL_W-1:0]  mul_b_o,
  output logic        [NUM_W-1:0]  div_num_o,
  output logic        [DEN_W-1:0]  div_den_o,
  input  logic                     arith_done_i,
  input  logic signed [PROD_W-1:0] prod_i,
  input  logic        [GAIN_W-1:0] quot_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_DET0  = 4'd2;
  localparam logic [3:0] S_DET1  = 4'd3;
  localparam logic [3:0] S_GNUM  = 4'd4;
  localparam logic [3:0] S_GDIV  = 4'd5;
  localparam logic [3:0] S_UPA   = 4'd6;
  localparam logic [3:0] S_UPB   = 4'd7;
  localparam logic [3:0] S_COV   = 4'd8;
  localparam logic [3:0] S_WRITE = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  function automatic logic signed [31:0] sat_to32(input logic signed [40:0] v);
    logic signed [31:0] res;
    if (v > 41'sd2147483647) res = 32'sh7fff_ffff;
    else if (v < -41'sd2147483648) res = 32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  function automatic logic signed [47:0] sat_to48(input logic signed [50:0] v);
    logic signed [47:0] res;
    if (v > 51'sh7fff_ffff_ffff) res = 48'sh7fff_ffff_ffff;
    else if (v < -51'sh8000_0000_0000) res = 48'sh8000_0000_0000;
    else res = v[47:0];
    return res;
  endfunction

  logic [3:0] state_q, state_d;
  logic       ax_q, ax_d;
  logic [1:0] k_q, k_d;
  logic       op_busy_q, op_busy_d;

  logic signed [31:0] cur_q [2], cur_d [2];
  logic signed [31:0] prv_q [2], prv_d [2];
  logic signed [31:0] pos_q [2], pos_d [2];
  logic signed [31:0] vel_q [2], vel_d [2];
  logic signed [47:0] cov_q [2][4], cov_d [2][4];

  logic signed [32:0]  zp_q, zp_d, zv_q, zv_d;
  logic signed [33:0]  ep_q, ep_d, ev_q, ev_d;
  logic signed [48:0]  s00_q, s00_d, s11_q, s11_d;
  logic        [DEN_W-1:0] det_q, det_d;
  logic        [NUM_W-1:0] num_q, num_d;
  logic signed [33:0]  m_q [4], m_d [4];
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic signed [39:0]  pp_q, pp_d, pv_q, pv_d;
  logic signed [47:0]  n_q [4], n_d [4];

  logic               op_state, fire;
  logic signed [31:0] xp, xv;
  logic signed [47:0] ca, cb, cc, cd;
  logic signed [49:0] adj;
  logic        [49:0] adj_mag;
  logic [1:0]         m_idx;
  logic signed [33:0] m_sel;
  logic signed [34:0] cov_op;
  logic signed [PROD_W-1:0] det_full, t_sum, rsum_t, rsum_p;
  logic signed [39:0] rnd, zsel;

  assign xp = pos_q[ax_q];
  assign xv = vel_q[ax_q];
  assign ca = cov_q[ax_q][0];
  assign cb = cov_q[ax_q][1];
  assign cc = cov_q[ax_q][2];
  assign cd = cov_q[ax_q][3];

  assign op_state = (state_q == S_DET0) || (state_q == S_DET1) || (state_q == S_GNUM) ||
                    (state_q == S_GDIV) || (state_q == S_UPA) || (state_q == S_UPB) ||
                    (state_q == S_COV);
  assign fire = op_busy_q && arith_done_i;

  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  // Gain numerator uses the adjugate entries s11, -b, -c, s00 in turn.
  always_comb begin
    unique case (k_q)
      2'd0: adj = 50'(s11_q);
      2'd1: adj = -50'(cb);
      2'd2: adj = -50'(cc);
      default: adj = 50'(s00_q);
    endcase
    adj_mag = adj[49] ? 50'(-adj) : 50'(adj);
  end

  always_comb begin
    unique case (state_q)
      S_UPA:   m_idx = {k_q[0], 1'b0};
      S_UPB:   m_idx = {k_q[0], 1'b1};
      default: m_idx = k_q;
    endcase
    m_sel = m_q[m_idx];
    if ((k_q == 2'd0) || (k_q == 2'd3)) begin
      cov_op = 35'sh1_0000_0000 - 35'(m_sel);
    end else begin
      cov_op = -35'(m_sel);
    end
  end

  assign det_full = acc_q - prod_i;
  assign t_sum    = acc_q + prod_i;
  assign rsum_t   = t_sum + 128'sh8000_0000;
  assign rsum_p   = prod_i + 128'sh8000_0000;
  assign rnd      = rsum_t[71:32];
  assign zsel     = k_q[0] ? 40'(zv_q) : 40'(zp_q);

  // Operand selection for the shared unit.
  always_comb begin
    arith_req_o.start  = op_state && !op_busy_q;
    arith_req_o.is_div = (state_q == S_GDIV);
    mul_a_o   = '0;
    mul_b_o   = '0;
    div_num_o = num_q;
    div_den_o = det_q;
    unique case (state_q)
      S_DET0: begin
        mul_a_o = 64'(s00_q);
        mul_b_o = 64'(s11_q);
      end
      S_DET1: begin
        mul_a_o = 64'(cb);
        mul_b_o = 64'(cc);
      end
      S_GNUM: begin
        mul_a_o = $signed({32'd0, r_i});
        mul_b_o = $signed({14'd0, adj_mag});
      end
      S_UPA: begin
        mul_a_o = 64'(m_sel);
        mul_b_o = 64'(ep_q);
      end
      S_UPB: begin
        mul_a_o = 64'(m_sel);
        mul_b_o = 64'(ev_q);
      end
      S_COV: begin
        mul_a_o = $signed({32'd0, r_i});
        mul_b_o = 64'(cov_op);
      end
      default: begin
        mul_a_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ax_d      = ax_q;
    k_d       = k_q;
    op_busy_d = op_busy_q;
    cur_d     = cur_q;
    prv_d     = prv_q;
    pos_d     = pos_q;
    vel_d     = vel_q;
    cov_d     = cov_q;
    zp_d      = zp_q;
    zv_d      = zv_q;
    ep_d      = ep_q;
    ev_d      = ev_q;
    s00_d     = s00_q;
    s11_d     = s11_q;
    det_d     = det_q;
    num_d     = num_q;
    m_d       = m_q;
    acc_d     = acc_q;
    pp_d      = pp_q;
    pv_d      = pv_q;
    n_d       = n_q;

    if (arith_req_o.start) begin
      op_busy_d = 1'b1;
    end else if (fire) begin
      op_busy_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d[0] = cur_x_i;
          cur_d[1] = cur_y_i;
          prv_d[0] = prev_x_i;
          prv_d[1] = prev_y_i;
          ax_d     = 1'b0;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        zp_d    = 33'(cur_q[ax_q]);
        zv_d    = 33'(cur_q[ax_q]) - 33'(prv_q[ax_q]);
        ep_d    = 34'(cur_q[ax_q]) - 34'(xp);
        ev_d    = 34'(33'(cur_q[ax_q]) - 33'(prv_q[ax_q])) - 34'(xv);
        s00_d   = 49'(ca) + $signed({17'd0, r_i});
        s11_d   = 49'(cd) + $signed({17'd0, r_i});
        state_d = S_DET0;
      end
      S_DET0: begin
        if (fire) begin
          acc_d   = prod_i;
          state_d = S_DET1;
        end
      end
      S_DET1: begin
        if (fire) begin
          det_d = det_full[DEN_W-1:0];
          k_d   = 2'd0;
          if (det_full[PROD_W-1] || (det_full == '0)) begin
            // Singular innovation: no correction, the prior carries over.
            pp_d    = 40'(xp);
            pv_d    = 40'(xv);
            n_d[0]  = ca;
            n_d[1]  = cb;
            n_d[2]  = cc;
            n_d[3]  = cd;
            state_d = S_WRITE;
          end else begin
            state_d = S_GNUM;
          end
        end
      end
      S_GNUM: begin
        if (fire) begin
          num_d   = {prod_i[80:0], 32'd0};
          state_d = S_GDIV;
        end
      end
      S_GDIV: begin
        if (fire) begin
          m_d[k_q] = adj[49] ? -34'($signed({1'b0, quot_i})) : 34'($signed({1'b0, quot_i}));
          k_d      = k_q + 2'd1;
          state_d  = (k_q == 2'd3) ? S_UPA : S_GNUM;
        end
      end
      S_UPA: begin
        if (fire) begin
          acc_d   = prod_i;
          state_d = S_UPB;
        end
      end
      S_UPB: begin
        if (fire) begin
          if (k_q[0]) begin
            pv_d    = zsel - rnd;
            k_d     = 2'd0;
            state_d = S_COV;
          end else begin
            pp_d    = zsel - rnd;
            k_d     = 2'd1;
            state_d = S_UPA;
          end
        end
      end
      S_COV: begin
        if (fire) begin
          n_d[k_q] = rsum_p[79:32];
          k_d      = k_q + 2'd1;
          state_d  = (k_q == 2'd3) ? S_WRITE : S_COV;
        end
      end
      S_WRITE: begin
        pos_d[ax_q]    = sat_to32(41'(pp_q) + 41'(pv_q));
        vel_d[ax_q]    = sat_to32(41'(pv_q));
        cov_d[ax_q][0] = sat_to48(51'(n_q[0]) + 51'(n_q[1]) + 51'(n_q[2]) + 51'(n_q[3]) +
                                  $signed({19'd0, qn_i}));
        cov_d[ax_q][1] = sat_to48(51'(n_q[1]) + 51'(n_q[3]));
        cov_d[ax_q][2] = sat_to48(51'(n_q[2]) + 51'(n_q[3]));
        cov_d[ax_q][3] = sat_to48(51'(n_q[3]) + $signed({19'd0, qn_i}));
        k_d            = 2'd0;
        if (!ax_q) begin
          ax_d    = 1'b1;
          state_d = S_LOAD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free_i) begin
          ax_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ax_q      <= 1'b0;
      k_q       <= 2'd0;
      op_busy_q <= 1'b0;
      pos_q     <= '{default: '0};
      vel_q     <= '{default: '0};
      cov_q     <= '{default: '{default: '0}};
    end else begin
      state_q   <= state_d;
      ax_q      <= ax_d;
      k_q       <= k_d;
      op_busy_q <= op_busy_d;
      pos_q     <= pos_d;
      vel_q     <= vel_d;
      cov_q     <= cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    prv_q <= prv_d;
    zp_q  <= zp_d;
    zv_q  <= zv_d;
    ep_q  <= ep_d;
    ev_q  <= ev_d;
    s00_q <= s00_d;
    s11_q <= s11_d;
    det_q <= det_d;
    num_q <= num_d;
    m_q   <= m_d;
    acc_q <= acc_d;
    pp_q  <= pp_d;
    pv_q  <= pv_d;
    n_q   <= n_d;
  end

endmodule
`default_nettype wire

// File: src/constant_velocity_kalman_tracker.sv
// An accepted item is run through the x and y axes in turn; its result comes sooner when
// both axes see a singular innovation, and on each axis the four gain divisions dominate.
// The next item is taken once the sequencer is idle again.
// The shared unit runs 14 multiplies and 4 divisions per axis. Reset clears state,
// covariance and the output valid flag, and loads the noise defaults.
`default_nettype none
// ---------------------------------------------------------------------------
// constant_velocity_kalman_tracker
// Four-state constant-velocity Kalman tracker with saturated Q16.16 output.
// ---------------------------------------------------------------------------
`include "constant_velocity_kalman_tracker_assert.svh"
module constant_velocity_kalman_tracker import cvkt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    cur_x_i,
  input  logic signed [31:0]    cur_y_i,
  input  logic signed [31:0]    prev_x_i,
  input  logic signed [31:0]    prev_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    pred_x_o,
  output logic signed [31:0]    pred_y_o
);

  // Noise registers. Writes to an index past the list are dropped.
  logic [CFG_W-1:0] process_noise_q, measurement_noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      process_noise_q     <= PROCESS_NOISE_RESET;
      measurement_noise_q <= MEASUREMENT_NOISE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PROCESS_NOISE) begin
        process_noise_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_MEASUREMENT_NOISE) begin
        measurement_noise_q <= cfg_data_i;
      end
    end
  end

  logic                     idle;
  logic                     res_valid;
  logic                     res_free;
  logic signed [31:0]       pos_x, pos_y;
  cvkt_arith_req_t          arith_req;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic        [NUM_W-1:0]  div_num;
  logic        [DEN_W-1:0]  div_den;
  logic                     arith_done;
  logic signed [PROD_W-1:0] prod;
  logic        [GAIN_W-1:0] quot;

  // The core only accepts a new item while its sequencer is idle.
  assign in_stall_o = !idle;

  cvkt_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .cur_x_i      (cur_x_i),
    .cur_y_i      (cur_y_i),
    .prev_x_i     (prev_x_i),
    .prev_y_i     (prev_y_i),
    .r_i          (measurement_noise_q),
    .qn_i         (process_noise_q),
    .res_free_i   (res_free),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .arith_req_o  (arith_req),
    .mul_a_o      (mul_a),
    .mul_b_o      (mul_b),
    .div_num_o    (div_num),
    .div_den_o    (div_den),
    .arith_done_i (arith_done),
    .prod_i       (prod),
    .quot_i       (quot)
  );

  cvkt_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (arith_req),
    .mul_a_i   (mul_a),
    .mul_b_i   (mul_b),
    .div_num_i (div_num),
    .div_den_i (div_den),
    .done_o    (arith_done),
    .prod_o    (prod),
    .quot_o    (quot)
  );

  // Output register: the finished prediction waits here while the core is
  // free to take the next item. The core holds its result until the slot frees.
  logic               out_valid_q;
  logic signed [31:0] pred_x_q, pred_y_q;

  assign res_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      pred_x_q <= pos_x;
      pred_y_q <= pos_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pred_x_o    = pred_x_q;
  assign pred_y_o    = pred_y_q;

  // An accepted item always puts the sequencer to work.
  `CVKT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // A new result only appears after the sequencer was busy with an item.
  `CVKT_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))
  // The shared unit is never restarted right after it was started.
  `CVKT_ASSERT_NEXT(a_no_restart, arith_req.start, !arith_req.start)

endmodule
`default_nettype wire
